/* hdl/lpht_pkg.sv */
// Package for the linear probe hash table: field widths, operation and
// result codes, slot marks, table entry and controller state types.
// No dependencies.
package lpht_pkg;

  localparam int unsigned KeyW    = 31;
  localparam int unsigned ActionW = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SlotW   = 10;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned DivCntW = 5;

  typedef enum logic [ActionW-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_CHECK  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [StatusW-1:0] {
    STS_INSERTED   = 3'd0,
    STS_PRESENT_OK = 3'd1,
    STS_GIVE_UP    = 3'd2,
    STS_DELETED    = 3'd3,
    STS_NOT_FOUND  = 3'd4,
    STS_FOUND      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_e;

  typedef struct packed {
    mark_e            mark;
    logic [KeyW-1:0]  key;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_PROBE,
    ST_WR_NEW,
    ST_WR_OLD,
    ST_DONE
  } state_e;

endpackage

/* hdl/lpht_if.sv */
// Request and response channel interfaces of the linear probe hash table.
// Depends on lpht_pkg for the field widths.
interface lpht_req_if;
  logic                          valid;
  logic                          ready;
  logic [lpht_pkg::ActionW-1:0]  action;
  logic [lpht_pkg::KeyW-1:0]     key;
  modport source (output valid, action, key, input ready);
  modport sink   (input valid, action, key, output ready);
endinterface

interface lpht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lpht_pkg::StatusW-1:0]  status;
  logic [lpht_pkg::SlotW-1:0]    slot_index;
  modport source (output valid, status, slot_index, input ready);
  modport sink   (input valid, status, slot_index, output ready);
endinterface

/* hdl/linear_probe_hash_table_unit.sv */
// Linear probe hash table with tombstones, held in one synchronous table RAM.
// Depends on lpht_pkg and the interfaces in lpht_if.sv.
//
// Use: requests (action, key) arrive on in_i, one response (status,
// slot_index) per request leaves on out_o; both are valid/ready channels.
// cfg_we_i/cfg_wdata_i write the slots-in-use register; write it only idle.
// One request is worked at a time. The home slot is found by a restoring
// divider (insert, check). A scan from slot 0 and a probe from home each
// read one entry a cycle through the single RAM read port; a request may
// scan and then probe, a check that moves its key scans once more, and the
// none action answers without either.
// After reset a clearing pass marks all SLOTS entries empty, one a cycle,
// before the first request is taken.
// The response sits in an output register; the next request is accepted
// while it waits, and work halts at the end of that request until the
// receiver takes the earlier response.
module linear_probe_hash_table_unit #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lpht_pkg::CfgW-1:0]   cfg_wdata_i,
  lpht_req_if.sink                    in_i,
  lpht_rsp_if.source                  out_o
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned RW = CW + 1;

  lpht_pkg::state_e              state_q, state_d;
  lpht_pkg::action_e             act_q, act_d;
  logic [lpht_pkg::KeyW-1:0]     key_q, key_d;
  logic [lpht_pkg::CfgW-1:0]     cfg_q;
  logic [CW-1:0]                 n_q, n_d, n_eff;
  logic [AW-1:0]                 home_q, home_d, cur_q, cur_d, new_q, new_d;
  logic                          reloc_q, reloc_d, final_q, final_d;
  lpht_pkg::status_e             res_status_q, res_status_d;
  logic [AW-1:0]                 res_slot_q, res_slot_d;
  logic [RW-1:0]                 rem_q, rem_d, rem_sh;
  logic [lpht_pkg::DivCntW-1:0]  div_cnt_q, div_cnt_d;
  logic [AW-1:0]                 ptr_q, ptr_d, paddr_q, paddr_d, ptr_nxt;
  logic [CW-1:0]                 left_q, left_d;
  logic                          pend_q, pend_d;
  logic [AW-1:0]                 clr_q, clr_d;
  logic                          out_valid_q, out_valid_d;
  lpht_pkg::status_e             out_status_q, out_status_d;
  logic [AW-1:0]                 out_slot_q, out_slot_d;

  lpht_pkg::entry_t              mem [SLOTS];
  lpht_pkg::entry_t              rdata_q, wdata;
  logic                          mem_we;
  logic [AW-1:0]                 waddr;
  logic                          issue, scan_hit, probe_hit, walk_miss, clr_last, out_free;
  logic [31:0]                   cfg_ext, slot_ext;

  // Clamp the register to 1..SLOTS
  always_comb begin
    cfg_ext = 32'(cfg_q);
    if (cfg_ext == 32'd0) begin
      n_eff = CW'(1);
    end else if (cfg_ext > SLOTS) begin
      n_eff = CW'(SLOTS);
    end else begin
      n_eff = CW'(cfg_ext);
    end
  end

  assign issue     = ((state_q == lpht_pkg::ST_SCAN) || (state_q == lpht_pkg::ST_PROBE))
                     && (left_q != '0);
  assign ptr_nxt   = (ptr_q == AW'(n_q - CW'(1))) ? '0 : ptr_q + AW'(1);
  assign scan_hit  = pend_q && (rdata_q.mark == lpht_pkg::MARK_USED) && (rdata_q.key == key_q);
  assign probe_hit = pend_q && (rdata_q.mark != lpht_pkg::MARK_USED);
  assign walk_miss = !pend_q && (left_q == '0);
  assign clr_last  = (clr_q == AW'(SLOTS - 1));
  assign out_free  = !out_valid_q || out_o.ready;
  assign rem_sh    = {rem_q[RW-2:0], key_q[div_cnt_q]};

  assign in_i.ready = (state_q == lpht_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpht_pkg::ST_CLEAR: if (clr_last) state_d = lpht_pkg::ST_IDLE;
      lpht_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          priority if (lpht_pkg::action_e'(in_i.action) == lpht_pkg::ACT_NONE) begin
            state_d = lpht_pkg::ST_DONE;
          end else if (lpht_pkg::action_e'(in_i.action) == lpht_pkg::ACT_DELETE) begin
            state_d = lpht_pkg::ST_SCAN;
          end else begin
            state_d = lpht_pkg::ST_DIV;
          end
        end
      end
      lpht_pkg::ST_DIV: if (div_cnt_q == '0) state_d = lpht_pkg::ST_SCAN;
      lpht_pkg::ST_SCAN: begin
        if (scan_hit) begin
          priority if (final_q) state_d = lpht_pkg::ST_DONE;
          else if (act_q == lpht_pkg::ACT_DELETE) state_d = lpht_pkg::ST_WR_OLD;
          else if (paddr_q == home_q) state_d = lpht_pkg::ST_DONE;
          else state_d = lpht_pkg::ST_PROBE;
        end else if (walk_miss) begin
          if (!final_q && (act_q == lpht_pkg::ACT_INSERT)) state_d = lpht_pkg::ST_PROBE;
          else state_d = lpht_pkg::ST_DONE;
        end
      end
      lpht_pkg::ST_PROBE: begin
        if (probe_hit) state_d = lpht_pkg::ST_WR_NEW;
        else if (walk_miss) state_d = lpht_pkg::ST_DONE;
      end
      lpht_pkg::ST_WR_NEW: state_d = reloc_q ? lpht_pkg::ST_WR_OLD : lpht_pkg::ST_DONE;
      lpht_pkg::ST_WR_OLD: begin
        state_d = (act_q == lpht_pkg::ACT_CHECK) ? lpht_pkg::ST_SCAN : lpht_pkg::ST_DONE;
      end
      lpht_pkg::ST_DONE: if (out_free) state_d = lpht_pkg::ST_IDLE;
      default: state_d = lpht_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    act_d        = act_q;
    key_d        = key_q;
    n_d          = n_q;
    home_d       = home_q;
    cur_d        = cur_q;
    new_d        = new_q;
    reloc_d      = reloc_q;
    final_d      = final_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    rem_d        = rem_q;
    div_cnt_d    = div_cnt_q;
    clr_d        = clr_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    mem_we       = 1'b0;
    waddr        = cur_q;
    wdata        = '{mark: lpht_pkg::MARK_DELETED, key: key_q};
    // advance the walk by default
    if (issue) begin
      ptr_d   = ptr_nxt;
      left_d  = left_q - CW'(1);
      pend_d  = 1'b1;
      paddr_d = ptr_q;
    end else begin
      ptr_d   = ptr_q;
      left_d  = left_q;
      pend_d  = 1'b0;
      paddr_d = paddr_q;
    end
    unique case (state_q)
      lpht_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        wdata  = '{mark: lpht_pkg::MARK_EMPTY, key: '0};
        clr_d  = clr_q + AW'(1);
      end
      lpht_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          act_d        = lpht_pkg::action_e'(in_i.action);
          key_d        = in_i.key;
          n_d          = n_eff;
          reloc_d      = 1'b0;
          final_d      = 1'b0;
          rem_d        = '0;
          div_cnt_d    = lpht_pkg::DivCntW'(lpht_pkg::KeyW - 1);
          res_status_d = lpht_pkg::STS_NOT_FOUND;
          res_slot_d   = '0;
          ptr_d        = '0;
          left_d       = n_eff;
        end
      end
      lpht_pkg::ST_DIV: begin
        rem_d     = (rem_sh >= RW'(n_q)) ? rem_sh - RW'(n_q) : rem_sh;
        div_cnt_d = div_cnt_q - lpht_pkg::DivCntW'(1);
        home_d    = AW'(rem_d);
        ptr_d     = '0;
        left_d    = n_q;
      end
      lpht_pkg::ST_SCAN: begin
        if (scan_hit) begin
          pend_d = 1'b0;
          cur_d  = paddr_q;
          priority if (final_q) begin
            res_status_d = lpht_pkg::STS_FOUND;
            res_slot_d   = paddr_q;
          end else if (act_q == lpht_pkg::ACT_DELETE) begin
            res_status_d = lpht_pkg::STS_DELETED;
            res_slot_d   = paddr_q;
          end else if (paddr_q == home_q) begin
            res_status_d = (act_q == lpht_pkg::ACT_CHECK) ? lpht_pkg::STS_FOUND
                                                          : lpht_pkg::STS_PRESENT_OK;
            res_slot_d   = paddr_q;
          end else begin
            // probe home up to, not including, the current slot
            reloc_d = 1'b1;
            ptr_d   = home_q;
            left_d  = (paddr_q >= home_q) ? CW'(paddr_q) - CW'(home_q)
                                          : CW'(paddr_q) + n_q - CW'(home_q);
          end
        end else if (walk_miss) begin
          ptr_d  = home_q;
          left_d = n_q;
        end
      end
      lpht_pkg::ST_PROBE: begin
        if (probe_hit) begin
          pend_d = 1'b0;
          new_d  = paddr_q;
        end else if (walk_miss) begin
          if (reloc_q && (act_q == lpht_pkg::ACT_CHECK)) begin
            res_status_d = lpht_pkg::STS_FOUND;
            res_slot_d   = cur_q;
          end else begin
            res_status_d = lpht_pkg::STS_GIVE_UP;
            res_slot_d   = '0;
          end
        end
      end
      lpht_pkg::ST_WR_NEW: begin
        mem_we       = 1'b1;
        waddr        = new_q;
        wdata        = '{mark: lpht_pkg::MARK_USED, key: key_q};
        res_status_d = reloc_q ? lpht_pkg::STS_PRESENT_OK : lpht_pkg::STS_INSERTED;
        res_slot_d   = new_q;
      end
      lpht_pkg::ST_WR_OLD: begin
        mem_we = 1'b1;
        // a moved key under check is looked up again from slot 0
        final_d = 1'b1;
        ptr_d   = '0;
        left_d  = n_q;
      end
      lpht_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpht_pkg::ST_CLEAR;
      cfg_q       <= lpht_pkg::CfgW'(1024);
      clr_q       <= '0;
      pend_q      <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    key_q        <= key_d;
    n_q          <= n_d;
    home_q       <= home_d;
    cur_q        <= cur_d;
    new_q        <= new_d;
    reloc_q      <= reloc_d;
    final_q      <= final_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    rem_q        <= rem_d;
    div_cnt_q    <= div_cnt_d;
    ptr_q        <= ptr_d;
    paddr_q      <= paddr_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

  // Table RAM, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (issue) rdata_q <= mem[ptr_q];
  end

  assign slot_ext         = 32'(out_slot_q);
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.slot_index = slot_ext[lpht_pkg::SlotW-1:0];

  a_no_rsp_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpht_pkg::ST_CLEAR) |-> !out_valid_q)
    else $error("response raised during clearing pass");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q != lpht_pkg::ST_CLEAR)) |-> (CW'(waddr) < n_q))
    else $error("table write beyond slots in use");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lpht_pkg::ST_SCAN) || (state_q == lpht_pkg::ST_PROBE)) |-> (left_q <= n_q))
    else $error("walk count exceeds slots in use");

  a_zero_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((out_status_q == lpht_pkg::STS_GIVE_UP)
                     || (out_status_q == lpht_pkg::STS_NOT_FOUND))) |-> (out_slot_q == '0))
    else $error("non-zero slot on miss or give-up");

endmodule
